### hdl/kml_pkg.sv
// kml_pkg: shared types and constants for the k-means iteration block.
// Used by the controller, datapath and top level; no dependencies.
package kml_pkg;

  localparam int unsigned MAX_CLUSTERS = 8;
  localparam int unsigned LAB_W        = 3;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned SQ_W         = 34;
  localparam int unsigned CNT_OUT_W    = 11;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // 10000 m^2 in Q16.16
  localparam logic [SQ_W-1:0] DIST_LIMIT = 34'd655360000;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_THRESH  = 2'd1;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_ITERATE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_CLR, ST_RD, ST_LATCH, ST_SQ, ST_CMP, ST_WB,
    ST_DIVX, ST_WAITX, ST_DIVY, ST_WAITY, ST_MSQ, ST_MCMP, ST_OUT, ST_OWAIT
  } state_t;

  typedef struct packed {
    logic clr_total;
    logic append;
    logic load_ctr;
    logic acc_clr;
    logic latch_pt;
    logic sq_pt;
    logic sq_move;
    logic cmp;
    logic wb;
    logic div_x;
    logic div_y;
    logic cap_x;
    logic cap_y;
    logic mcmp;
    logic out_load;
    logic c_clr;
    logic c_inc;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic last_pt;
    logic last_c;
    logic div_done;
    logic out_acc;
  } stat_t;

endpackage

### hdl/kml_ram.sv
// kml_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module kml_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/kml_div.sv
// kml_div: restoring serial divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, low 16 bits returned. No dependencies.
module kml_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic signed [15:0]   quotient
);

  localparam int unsigned IW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [NW-1:0] a_r, a_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   trial;
  logic [NW-1:0] q_signed;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    a_nxt    = a_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, a_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      neg_nxt  = dividend[NW-1];
      a_nxt    = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      q_nxt    = '0;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      a_nxt = {a_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = DW'(trial - {1'b0, d_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      it_nxt = it_r + 1'b1;
      if (it_r == IW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    it_r  <= it_nxt;
    a_r   <= a_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? NW'(-q_r) : q_r;
  assign quotient = q_signed[15:0];
  assign done     = done_r;

endmodule

### hdl/kml_ctrl.sv
// kml_ctrl: sequencer for the iterate pass and idle-time commands.
// Depends on kml_pkg.
module kml_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  output logic           in_stall,
  input  kml_pkg::stat_t st,
  output kml_pkg::cmd_t  cmd
);

  kml_pkg::state_t state_r, state_nxt;
  logic            acc;

  assign in_stall = (state_r != kml_pkg::ST_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kml_pkg::ST_IDLE:
        if (acc && kml_pkg::action_t'(in_action) == kml_pkg::ACT_ITERATE) begin
          state_nxt = kml_pkg::ST_ACC_CLR;
        end
      kml_pkg::ST_ACC_CLR: state_nxt = st.total_zero ? kml_pkg::ST_DIVX : kml_pkg::ST_RD;
      kml_pkg::ST_RD:      state_nxt = kml_pkg::ST_LATCH;
      kml_pkg::ST_LATCH:   state_nxt = kml_pkg::ST_SQ;
      kml_pkg::ST_SQ:      state_nxt = kml_pkg::ST_CMP;
      kml_pkg::ST_CMP:     state_nxt = st.last_c ? kml_pkg::ST_WB : kml_pkg::ST_SQ;
      kml_pkg::ST_WB:      state_nxt = st.last_pt ? kml_pkg::ST_DIVX : kml_pkg::ST_RD;
      kml_pkg::ST_DIVX:    state_nxt = kml_pkg::ST_WAITX;
      kml_pkg::ST_WAITX:   if (st.div_done) state_nxt = kml_pkg::ST_DIVY;
      kml_pkg::ST_DIVY:    state_nxt = kml_pkg::ST_WAITY;
      kml_pkg::ST_WAITY:   if (st.div_done) state_nxt = kml_pkg::ST_MSQ;
      kml_pkg::ST_MSQ:     state_nxt = kml_pkg::ST_MCMP;
      kml_pkg::ST_MCMP:    state_nxt = st.last_c ? kml_pkg::ST_OUT : kml_pkg::ST_DIVX;
      kml_pkg::ST_OUT:     state_nxt = kml_pkg::ST_OWAIT;
      kml_pkg::ST_OWAIT:
        if (st.out_acc) begin
          state_nxt = st.last_c ? kml_pkg::ST_IDLE : kml_pkg::ST_OUT;
        end
      default:             state_nxt = kml_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      kml_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (kml_pkg::action_t'(in_action))
            kml_pkg::ACT_CLEAR:   cmd.clr_total = 1'b1;
            kml_pkg::ACT_APPEND:  cmd.append    = 1'b1;
            kml_pkg::ACT_LOAD:    cmd.load_ctr  = 1'b1;
            kml_pkg::ACT_ITERATE: cmd.acc_clr   = 1'b1;
            default: ;
          endcase
        end
      end
      kml_pkg::ST_ACC_CLR: cmd.c_clr = 1'b1;
      kml_pkg::ST_RD: ;
      kml_pkg::ST_LATCH: begin
        cmd.latch_pt = 1'b1;
        cmd.c_clr    = 1'b1;
      end
      kml_pkg::ST_SQ: cmd.sq_pt = 1'b1;
      kml_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.c_inc = 1'b1;
      end
      kml_pkg::ST_WB: begin
        cmd.wb    = 1'b1;
        cmd.c_clr = 1'b1;
      end
      kml_pkg::ST_DIVX:  cmd.div_x = 1'b1;
      kml_pkg::ST_WAITX: cmd.cap_x = st.div_done;
      kml_pkg::ST_DIVY:  cmd.div_y = 1'b1;
      kml_pkg::ST_WAITY: cmd.cap_y = st.div_done;
      kml_pkg::ST_MSQ:   cmd.sq_move = 1'b1;
      kml_pkg::ST_MCMP: begin
        cmd.mcmp  = 1'b1;
        cmd.c_clr = st.last_c;
        cmd.c_inc = !st.last_c;
      end
      kml_pkg::ST_OUT:   cmd.out_load = 1'b1;
      kml_pkg::ST_OWAIT: cmd.c_inc = st.out_acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kml_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/kml_dp.sv
// kml_dp: point store, centers, accumulators, distance unit, divider and
// output register. Depends on kml_pkg, kml_ram and kml_div.
module kml_dp #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  kml_pkg::cmd_t                        cmd,
  output kml_pkg::stat_t                       st,
  input  logic                                 cfg_we,
  input  logic [kml_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kml_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [2:0]                           in_center_slot,
  input  logic signed [kml_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [kml_pkg::COORD_W-1:0]   in_coord_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_cluster_index,
  output logic signed [kml_pkg::COORD_W-1:0]   out_new_center_x,
  output logic signed [kml_pkg::COORD_W-1:0]   out_new_center_y,
  output logic [kml_pkg::CNT_OUT_W-1:0]        out_member_count,
  output logic                                 out_all_converged,
  output logic                                 out_last_result
);

  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned CW = PW + 1;
  localparam int unsigned SW = PW + 17;
  localparam int unsigned RW = 2 * kml_pkg::COORD_W + kml_pkg::LAB_W;
  localparam int unsigned NC = kml_pkg::MAX_CLUSTERS;
  localparam int unsigned CO = kml_pkg::COORD_W;

  logic [3:0]    ncl_r;
  logic [15:0]   thr_r;
  logic [CW-1:0] total_r;
  logic [PW-1:0] idx_r;
  logic [2:0]    c_r;

  logic signed [CO-1:0] cx_r [NC];
  logic signed [CO-1:0] cy_r [NC];
  logic signed [SW-1:0] sx_r [NC];
  logic signed [SW-1:0] sy_r [NC];
  logic [CW-1:0]        cnt_r [NC];

  logic signed [CO-1:0]          px_r, py_r, qx_r, qy_r;
  logic [kml_pkg::LAB_W-1:0]     blab_r;
  logic [kml_pkg::SQ_W-1:0]      best_r, sqx_r, sqy_r, dsq;
  logic                          conv_r;
  logic                          ov_r;
  logic [2:0]                    oidx_r;
  logic signed [CO-1:0]          ox_r, oy_r;
  logic [kml_pkg::CNT_OUT_W-1:0] ocnt_r;
  logic                          oconv_r, olast_r;

  logic [3:0]           kk;
  logic [2:0]           acc_sel;
  logic signed [CO-1:0] opx, opy;
  logic signed [CO:0]   dx, dy;
  logic signed [2*CO+1:0] dx2, dy2;
  logic                 ram_we;
  logic [PW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata, ram_rdata;
  logic                 div_start, div_done;
  logic signed [SW-1:0] div_num;
  logic signed [CO-1:0] div_q;
  logic [CW+kml_pkg::CNT_OUT_W-1:0] cnt_ext;
  logic                 out_acc;

  // active center count, saturated to 1..MAX_CLUSTERS
  always_comb begin
    if (ncl_r == 4'd0) kk = 4'd1;
    else if (ncl_r > 4'(NC)) kk = 4'(NC);
    else kk = ncl_r;
  end

  assign acc_sel = cmd.wb ? blab_r : c_r;
  assign out_acc = ov_r && !out_stall;

  assign st.total_zero = (total_r == '0);
  assign st.last_pt    = (({1'b0, idx_r} + 1'b1) == total_r);
  assign st.last_c     = ({1'b0, c_r} == (kk - 4'd1));
  assign st.div_done   = div_done;
  assign st.out_acc    = out_acc;

  // point word: {x, y, label}
  assign ram_we    = (cmd.append && (total_r < CW'(MAX_POINTS))) || cmd.wb;
  assign ram_waddr = cmd.wb ? idx_r : total_r[PW-1:0];
  assign ram_wdata = cmd.wb ? {px_r, py_r, blab_r}
                            : {in_coord_x, in_coord_y, kml_pkg::LAB_W'(0)};

  kml_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_pts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // squared distance: center vs point, or old center vs new mean
  assign opx  = cmd.sq_move ? qx_r : px_r;
  assign opy  = cmd.sq_move ? qy_r : py_r;
  assign dx   = (CO+1)'(cx_r[c_r]) - (CO+1)'(opx);
  assign dy   = (CO+1)'(cy_r[c_r]) - (CO+1)'(opy);
  assign dx2  = dx * dx;
  assign dy2  = dy * dy;
  assign dsq  = sqx_r + sqy_r;

  assign div_start = cmd.div_x || cmd.div_y;
  assign div_num   = cmd.div_y ? sy_r[c_r] : sx_r[c_r];

  kml_div #(.NW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cnt_r[c_r]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cnt_ext = {{kml_pkg::CNT_OUT_W{1'b0}}, cnt_r[c_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r   <= 4'd4;
      thr_r   <= 16'd66;
      total_r <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cx_r[i]  <= '0;
        cy_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == kml_pkg::CFG_NUM_CLUSTERS) ncl_r <= cfg_wdata[3:0];
        if (cfg_index == kml_pkg::CFG_CONV_THRESH)  thr_r <= cfg_wdata;
      end
      if (cmd.clr_total) total_r <= '0;
      else if (cmd.append && (total_r < CW'(MAX_POINTS))) total_r <= total_r + 1'b1;
      if (cmd.load_ctr) begin
        cx_r[in_center_slot] <= in_coord_x;
        cy_r[in_center_slot] <= in_coord_y;
      end
      if (cmd.mcmp) begin
        cx_r[c_r] <= qx_r;
        cy_r[c_r] <= qy_r;
      end
      if (cmd.out_load) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.c_clr) c_r <= '0;
    else if (cmd.c_inc) c_r <= c_r + 1'b1;

    if (cmd.acc_clr) begin
      idx_r  <= '0;
      conv_r <= 1'b1;
      for (int i = 0; i < NC; i++) begin
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end
    if (cmd.latch_pt) begin
      px_r   <= ram_rdata[RW-1 -: CO];
      py_r   <= ram_rdata[kml_pkg::LAB_W +: CO];
      blab_r <= ram_rdata[kml_pkg::LAB_W-1:0];
      best_r <= kml_pkg::DIST_LIMIT;
    end
    if (cmd.sq_pt || cmd.sq_move) begin
      sqx_r <= dx2[kml_pkg::SQ_W-1:0];
      sqy_r <= dy2[kml_pkg::SQ_W-1:0];
    end
    if (cmd.cmp && (dsq < best_r)) begin
      best_r <= dsq;
      blab_r <= c_r;
    end
    if (cmd.wb) begin
      idx_r <= idx_r + 1'b1;
      // a kept label at or above k joins no center
      if ({1'b0, blab_r} < kk) begin
        sx_r[acc_sel]  <= sx_r[acc_sel] + SW'(px_r);
        sy_r[acc_sel]  <= sy_r[acc_sel] + SW'(py_r);
        cnt_r[acc_sel] <= cnt_r[acc_sel] + 1'b1;
      end
    end
    if (cmd.cap_x) qx_r <= (cnt_r[c_r] == '0) ? '0 : div_q;
    if (cmd.cap_y) qy_r <= (cnt_r[c_r] == '0) ? '0 : div_q;
    if (cmd.mcmp && !(dsq < {18'd0, thr_r})) conv_r <= 1'b0;
    if (cmd.out_load) begin
      oidx_r  <= c_r;
      ox_r    <= cx_r[c_r];
      oy_r    <= cy_r[c_r];
      ocnt_r  <= cnt_ext[kml_pkg::CNT_OUT_W-1:0];
      oconv_r <= conv_r;
      olast_r <= st.last_c;
    end
  end

  assign out_valid         = ov_r;
  assign out_cluster_index = oidx_r;
  assign out_new_center_x  = ox_r;
  assign out_new_center_y  = oy_r;
  assign out_member_count  = ocnt_r;
  assign out_all_converged = oconv_r;
  assign out_last_result   = olast_r;

endmodule

### hdl/kmeans_lloyd_iteration.sv
// kmeans_lloyd_iteration: one Lloyd k-means pass over stored 2-D Q8.8 points.
// Ties kml_ctrl and kml_dp together; depends on kml_pkg.
//
// Clear, append and load-center words are taken without stalling the input.
// An iterate word holds the input stalled while each stored point is read
// from the point RAM and compared against the active centers in turn
// with a single squared-distance unit, then each mean is formed by
// a shared bit-serial divider (one quotient bit per cycle, x then y).
// Results come one per center in index order, the last flagged; the input
// stays stalled until the last result is taken.
module kmeans_lloyd_iteration #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [kml_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kml_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_action,
  input  logic [2:0]                          in_center_slot,
  input  logic signed [kml_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [kml_pkg::COORD_W-1:0]  in_coord_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_cluster_index,
  output logic signed [kml_pkg::COORD_W-1:0]  out_new_center_x,
  output logic signed [kml_pkg::COORD_W-1:0]  out_new_center_y,
  output logic [kml_pkg::CNT_OUT_W-1:0]       out_member_count,
  output logic                                out_all_converged,
  output logic                                out_last_result
);

  kml_pkg::cmd_t  cmd;
  kml_pkg::stat_t st;

  kml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .st        (st),
    .cmd       (cmd)
  );

  kml_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_center_slot    (in_center_slot),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cluster_index (out_cluster_index),
    .out_new_center_x  (out_new_center_x),
    .out_new_center_y  (out_new_center_y),
    .out_member_count  (out_member_count),
    .out_all_converged (out_all_converged),
    .out_last_result   (out_last_result)
  );

endmodule

### hdl/kml_chk.sv
// kml_chk: port-level assertions for kmeans_lloyd_iteration, bound to the top.
// Depends on kml_pkg.
module kml_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [2:0]                         out_cluster_index,
  input logic signed [kml_pkg::COORD_W-1:0] out_new_center_x,
  input logic signed [kml_pkg::COORD_W-1:0] out_new_center_y,
  input logic [kml_pkg::CNT_OUT_W-1:0]      out_member_count,
  input logic                               out_last_result
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cluster_index))
    else $error("stalled result word changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid)
    else $error("result word after last of run");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_member_count == '0 |->
      out_new_center_x == '0 && out_new_center_y == '0)
    else $error("empty center not at origin");

endmodule

bind kmeans_lloyd_iteration kml_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cluster_index (out_cluster_index),
  .out_new_center_x  (out_new_center_x),
  .out_new_center_y  (out_new_center_y),
  .out_member_count  (out_member_count),
  .out_last_result   (out_last_result)
);
